@@ rtl/rse_pkg.sv @@
// ----------------------------------------------------------------------------
// rse_pkg
// Shared widths, codes and result types of the run-length sprite encoder.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned ADDR_W    = 25;
  localparam int unsigned VAL_W     = 26;
  localparam int unsigned RUN_W     = 8;
  localparam int unsigned RES_SLOTS = 6;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = ((ADDR_W + VAL_W + 7) / 8) * 8;
  localparam int unsigned PAD_W     = M_TDATA_W - ADDR_W - VAL_W;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [RUN_W-1:0] CLEAR_CAP = 8'hFE;
  localparam logic [RUN_W-1:0] VIS_CAP   = 8'hFF;
  localparam logic [PIX_W-1:0] EOL_BYTE  = 8'hFF;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_LINE = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
  } result_t;

  // Results caused by one pixel, in order; cnt of them are meaningful.
  typedef struct packed {
    logic [CNT_W-1:0]              cnt;
    result_t [RES_SLOTS-1:0]       res;
  } batch_t;

  function automatic result_t mk_res(kind_e k, logic [ADDR_W-1:0] a,
                                     logic [VAL_W-1:0] v);
    result_t r;
    r.kind  = k;
    r.addr  = a;
    r.value = v;
    return r;
  endfunction

  function automatic result_t mk_byte(logic [ADDR_W-1:0] a, logic [PIX_W-1:0] b);
    return mk_res(KIND_DATA, a, VAL_W'(b));
  endfunction

endpackage

@@ rtl/rse_encode.sv @@
// ----------------------------------------------------------------------------
// rse_encode
// Pixel input register, run/position state and the single-pass encode logic.
// ----------------------------------------------------------------------------
module rse_encode (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pix_valid_i,
  output logic                         pix_ready_o,
  input  logic [rse_pkg::PIX_W-1:0]    pix_i,
  input  logic [rse_pkg::DIM_W-1:0]    width_i,
  input  logic [rse_pkg::DIM_W-1:0]    height_i,
  input  logic                         batch_free_i,
  output logic                         batch_load_o,
  output rse_pkg::batch_t              batch_o
);
  import rse_pkg::*;

  logic                 pix_valid_q;
  logic [PIX_W-1:0]     pix_q;
  logic                 vis_q, vis_d;
  logic [RUN_W-1:0]     rc_q, rc_d;
  logic [DIM_W-1:0]     col_q, col_d;
  logic [DIM_W-1:0]     row_q, row_d;
  logic [ADDR_W-1:0]    wp_q, wp_d;
  logic [ADDR_W-1:0]    cs_q, cs_d;
  logic [CNT_W-1:0]     n;
  result_t [RES_SLOTS-1:0] res;
  logic                 open_vis;
  logic [RUN_W-1:0]     open_clear;

  assign batch_load_o = pix_valid_q && batch_free_i;
  assign pix_ready_o  = !pix_valid_q || batch_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else if (pix_ready_o) begin
      pix_valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_ready_o && pix_valid_i) begin
      pix_q <= pix_i;
    end
  end

  // Walk the pixel through row start, run update and row end, collecting writes.
  always_comb begin
    vis_d      = vis_q;
    rc_d       = rc_q;
    col_d      = col_q;
    row_d      = row_q;
    wp_d       = wp_q;
    cs_d       = cs_q;
    n          = '0;
    res        = '0;
    open_vis   = 1'b0;
    open_clear = '0;

    if (col_d == '0) begin
      if (row_d >= height_i) begin
        row_d = '0;
        wp_d  = '0;
      end
      res[n] = mk_res(KIND_LINE, ADDR_W'(row_d),
                      VAL_W'({height_i - row_d, 2'b00}) + VAL_W'(wp_d));
      n      = n + CNT_W'(1);
      vis_d  = 1'b0;
      rc_d   = '0;
    end

    if (!vis_d) begin
      if (pix_q == '0) begin
        if (rc_d >= CLEAR_CAP) begin
          res[n] = mk_byte(wp_d, CLEAR_CAP);
          n      = n + CNT_W'(1);
          wp_d   = wp_d + ADDR_W'(1);
          res[n] = mk_byte(wp_d, '0);
          n      = n + CNT_W'(1);
          wp_d   = wp_d + ADDR_W'(1);
          rc_d   = RUN_W'(1);
        end else begin
          rc_d = rc_d + RUN_W'(1);
        end
      end else begin
        open_vis   = 1'b1;
        open_clear = rc_d;
      end
    end else begin
      if (pix_q == '0) begin
        res[n] = mk_res(KIND_DATA, cs_d, VAL_W'(rc_d));
        n      = n + CNT_W'(1);
        vis_d  = 1'b0;
        rc_d   = RUN_W'(1);
      end else if (rc_d >= VIS_CAP) begin
        res[n]     = mk_res(KIND_DATA, cs_d, VAL_W'(rc_d));
        n          = n + CNT_W'(1);
        open_vis   = 1'b1;
        open_clear = '0;
      end else begin
        res[n] = mk_byte(wp_d, pix_q);
        n      = n + CNT_W'(1);
        wp_d   = wp_d + ADDR_W'(1);
        rc_d   = rc_d + RUN_W'(1);
      end
    end

    // clear count, reserved count slot, first visible pixel
    if (open_vis) begin
      res[n] = mk_byte(wp_d, open_clear);
      n      = n + CNT_W'(1);
      wp_d   = wp_d + ADDR_W'(1);
      cs_d   = wp_d;
      wp_d   = wp_d + ADDR_W'(1);
      res[n] = mk_byte(wp_d, pix_q);
      n      = n + CNT_W'(1);
      wp_d   = wp_d + ADDR_W'(1);
      vis_d  = 1'b1;
      rc_d   = RUN_W'(1);
    end

    col_d = col_d + DIM_W'(1);
    if (col_d >= width_i || col_d == '0) begin
      if (vis_d) begin
        res[n] = mk_res(KIND_DATA, cs_d, VAL_W'(rc_d));
        n      = n + CNT_W'(1);
      end
      res[n] = mk_byte(wp_d, EOL_BYTE);
      n      = n + CNT_W'(1);
      wp_d   = wp_d + ADDR_W'(1);
      vis_d  = 1'b0;
      rc_d   = '0;
      col_d  = '0;
      row_d  = row_d + DIM_W'(1);
      if (row_d >= height_i) begin
        row_d = '0;
        wp_d  = '0;
      end
    end
  end

  assign batch_o.cnt = n;
  assign batch_o.res = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= 1'b0;
      rc_q  <= '0;
      col_q <= '0;
      row_q <= '0;
      wp_q  <= '0;
      cs_q  <= '0;
    end else if (batch_load_o) begin
      vis_q <= vis_d;
      rc_q  <= rc_d;
      col_q <= col_d;
      row_q <= row_d;
      wp_q  <= wp_d;
      cs_q  <= cs_d;
    end
  end

endmodule

@@ rtl/rse_out_seq.sv @@
// ----------------------------------------------------------------------------
// rse_out_seq
// Result register: holds one pixel's writes and hands them out one per beat.
// ----------------------------------------------------------------------------
module rse_out_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 batch_load_i,
  input  rse_pkg::batch_t      batch_i,
  output logic                 batch_free_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output rse_pkg::result_t     res_o,
  output logic                 res_last_o
);
  import rse_pkg::*;

  logic             valid_q, valid_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  batch_t           batch_q;
  logic             take;

  assign res_valid_o  = valid_q;
  assign res_o        = batch_q.res[idx_q];
  assign res_last_o   = (idx_q == batch_q.cnt - CNT_W'(1));
  assign take         = valid_q && res_ready_i;
  assign batch_free_o = !valid_q || (take && res_last_o);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (batch_free_o) begin
      valid_d = batch_load_i && (batch_i.cnt != '0);
      idx_d   = '0;
    end else if (take) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (batch_free_o && batch_load_i) begin
      batch_q <= batch_i;
    end
  end

endmodule

@@ rtl/rle_sprite_encoder.sv @@
// ----------------------------------------------------------------------------
// rle_sprite_encoder
// Transparent run-length sprite encoder: palette pixels in, addressed writes
// of row data bytes and line-table entries out.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Payload                                   | Transaction
//  ---------+-----+-------------------------------------------+------------------
//  s_axis   | in  | tdata[7:0] pixel                          | tvalid & tready
//  m_axis   | out | tuser kind, tdata address/value, tlast    | tvalid & tready
//  cfg      | in  | cfg_addr_i index, cfg_data_i value        | cfg_we_i
//
//  A pixel sits in the input register, then the encode logic puts all its
//  writes (0 to 5) into the result register in a single pass.
//  The result register sends one write per cycle while m_axis_tready is
//  high; a pixel needing several writes holds the input side until its last
//  write leaves. The next pixel is taken in the cycle the last write of the
//  previous one leaves, so the output port sets the rate.
//  Reset clears run state, position, pointers and the handshake; there is
//  no clearing pass. Registers are reset to width 1, height 1.
//
module rle_sprite_encoder #(
  parameter int unsigned MaxWidth  = 4096,
  parameter int unsigned MaxHeight = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave: pixel stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rse_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [7:0] pixel
  // master: write stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rse_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // [24:0] address,
                                                          // [50:25] value, [55:51] 0
  output logic                            m_axis_tuser,   // [0] kind
  output logic                            m_axis_tlast,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [rse_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [rse_pkg::DIM_W-1:0]       cfg_data_i
);
  import rse_pkg::*;

  // Caps are limited to what a 13-bit register can hold anyway.
  localparam int unsigned DimMax = (1 << DIM_W) - 1;
  localparam logic [DIM_W-1:0] WidthCap  = DIM_W'((MaxWidth  > DimMax) ? DimMax : MaxWidth);
  localparam logic [DIM_W-1:0] HeightCap = DIM_W'((MaxHeight > DimMax) ? DimMax : MaxHeight);

  logic [DIM_W-1:0] width_q, height_q;
  logic [DIM_W-1:0] width_d, height_d;
  logic             batch_free;
  logic             batch_load;
  batch_t           batch;
  result_t          res;

  // Registers hold the clamped dimension: zero acts as one, above max as max.
  always_comb begin
    width_d  = (cfg_data_i == '0) ? DIM_W'(1) :
               (cfg_data_i > WidthCap) ? WidthCap : cfg_data_i;
    height_d = (cfg_data_i == '0) ? DIM_W'(1) :
               (cfg_data_i > HeightCap) ? HeightCap : cfg_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_WIDTH:  width_q  <= width_d;
        CFG_HEIGHT: height_q <= height_d;
        default: ;
      endcase
    end
  end

  rse_encode u_encode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_o  (s_axis_tready),
    .pix_i        (s_axis_tdata[PIX_W-1:0]),
    .width_i      (width_q),
    .height_i     (height_q),
    .batch_free_i (batch_free),
    .batch_load_o (batch_load),
    .batch_o      (batch)
  );

  rse_out_seq u_out_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .batch_load_i (batch_load),
    .batch_i      (batch),
    .batch_free_o (batch_free),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res),
    .res_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, res.value, res.addr};
  assign m_axis_tuser = res.kind;

endmodule

@@ rtl/rse_checker.sv @@
// ----------------------------------------------------------------------------
// rse_checker
// Port-level checks on the sprite encoder's write stream, bound to the top.
// ----------------------------------------------------------------------------
module rse_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tready,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [rse_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input  logic                            m_axis_tuser,
  input  logic                            m_axis_tlast
);
  import rse_pkg::*;

  // A stalled write holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled write changed");

  // Nothing pending downstream means the pixel side must be open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("pixel side blocked with empty result register");

  // Data writes carry a byte only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_DATA) |->
      m_axis_tdata[M_TDATA_W-1:ADDR_W+PIX_W] == '0)
    else $error("data write wider than a byte");

  // A line-table offset always skips at least one table entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_LINE) |->
      m_axis_tdata[ADDR_W+VAL_W-1:ADDR_W+2] != '0)
    else $error("line-table offset below one entry");

endmodule

bind rle_sprite_encoder rse_checker u_rse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
